### hdl/vttc_pkg.sv
// Shared types and codes for the valve travel timer controller.
// Used by vttc_cfg_regs, vttc_core and valve_travel_timer_controller; no dependencies.
package vttc_pkg;

  // Command codes carried by each input item
  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_OPEN      = 3'd1,
    CMD_CLOSE     = 3'd2,
    CMD_DIVERTER  = 3'd3,
    CMD_PUMP_ON   = 3'd4,
    CMD_PUMP_OFF  = 3'd5,
    CMD_SAFE      = 3'd6
  } cmd_t;

  // Configuration register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_ZONE_COUNT     = 2'd0,
    REG_ZONE_TRAVEL    = 2'd1,
    REG_DIVERTER_TRAVEL = 2'd2
  } reg_idx_t;

  localparam logic [3:0]  ZONE_COUNT_RST = 4'd8;
  localparam int          OUT_ZONES      = 8;

  typedef struct packed {
    logic [3:0]  zone_count;
    logic [15:0] zone_travel_ms;
    logic [15:0] diverter_travel_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  zone;
    logic        fertigate;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [7:0] zone_levels;
    logic [7:0] zone_busy;
    logic       diverter_fert;
    logic       diverter_busy;
    logic       pump_on;
    logic       any_busy;
  } result_t;

endpackage

### hdl/valve_travel_timer_controller.sv
// Top level of the valve travel timer controller: input register, core, result register.
// Depends on vttc_pkg, vttc_cfg_regs and vttc_core.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  in_      | in_valid / in_stall  | cmd, zone, fertigate, now_ms
//  out_     | out_valid / out_stall| zone_levels, zone_busy, diverter_fert/busy, pump_on, any_busy
//  config   | psel/penable/pwrite  | paddr, pwdata, prdata, pready (always ready)
//
// One item per cycle sustained while out_stall is low; results are registered after the core.
// The single pass is one 32-bit subtract and compare per zone timer, all zones in parallel.
// rst_n is synchronous: it clears drive levels, timer flags and both stage valids; registers
// return to zone count 8 and zero travel times.
// A stalled result holds; one more item is still taken into the input register.
module valve_travel_timer_controller #(
  parameter int ZONES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [3:0]  in_zone,
  input  logic        in_fertigate,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_zone_levels,
  output logic [7:0]  out_zone_busy,
  output logic        out_diverter_fert,
  output logic        out_diverter_busy,
  output logic        out_pump_on,
  output logic        out_any_busy,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  vttc_pkg::cfg_t    cfg;
  vttc_pkg::item_t   s1_item_r;
  vttc_pkg::result_t res;
  vttc_pkg::result_t out_res_r;
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic advance, fire, accept;

  vttc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vttc_core #(.ZONES(ZONES)) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Handshake: advance when the result register is empty or being taken
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the accepted item and the finished result
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r.cmd       <= in_cmd;
      s1_item_r.zone      <= in_zone;
      s1_item_r.fertigate <= in_fertigate;
      s1_item_r.now_ms    <= in_now_ms;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_zone_levels   = out_res_r.zone_levels;
  assign out_zone_busy     = out_res_r.zone_busy;
  assign out_diverter_fert = out_res_r.diverter_fert;
  assign out_diverter_busy = out_res_r.diverter_busy;
  assign out_pump_on       = out_res_r.pump_on;
  assign out_any_busy      = out_res_r.any_busy;

endmodule

### hdl/vttc_cfg_regs.sv
// APB-style configuration registers: zone count and travel times.
// Depends on vttc_pkg.
module vttc_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output vttc_pkg::cfg_t     cfg
);

  logic [3:0]  zone_count_r;
  logic [15:0] zone_travel_r;
  logic [15:0] div_travel_r;
  logic        wr_en;
  vttc_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign idx    = vttc_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  // Write the addressed register at the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_count_r  <= vttc_pkg::ZONE_COUNT_RST;
      zone_travel_r <= '0;
      div_travel_r  <= '0;
    end else if (wr_en) begin
      unique case (idx)
        vttc_pkg::REG_ZONE_COUNT:      zone_count_r  <= pwdata[3:0];
        vttc_pkg::REG_ZONE_TRAVEL:     zone_travel_r <= pwdata[15:0];
        vttc_pkg::REG_DIVERTER_TRAVEL: div_travel_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (idx)
      vttc_pkg::REG_ZONE_COUNT:      prdata = {28'd0, zone_count_r};
      vttc_pkg::REG_ZONE_TRAVEL:     prdata = {16'd0, zone_travel_r};
      vttc_pkg::REG_DIVERTER_TRAVEL: prdata = {16'd0, div_travel_r};
      default:                       prdata = '0;
    endcase
  end

  assign cfg.zone_count         = zone_count_r;
  assign cfg.zone_travel_ms     = zone_travel_r;
  assign cfg.diverter_travel_ms = div_travel_r;

endmodule

### hdl/vttc_core.sv
// Actuator state and per-item update: zone valves, diverter, pump and travel timers.
// Depends on vttc_pkg; state changes only when the top level fires an item.
module vttc_core #(
  parameter int ZONES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  vttc_pkg::item_t   item,
  input  vttc_pkg::cfg_t    cfg,
  output vttc_pkg::result_t res
);

  localparam logic [4:0] ZONES_W = 5'(ZONES);

  vttc_pkg::cmd_t cmd;
  logic [4:0]     n_use;
  logic [ZONES-1:0] in_use;
  logic [ZONES-1:0] level_r, level_nxt;
  logic [ZONES-1:0] active_r, active_nxt;
  logic [ZONES-1:0] busy;
  logic [31:0] start_r [ZONES];
  logic [31:0] start_nxt [ZONES];
  logic [15:0] dur_r [ZONES];
  logic [15:0] dur_nxt [ZONES];

  logic        div_fert_r, div_fert_nxt;
  logic        div_active_r, div_active_nxt;
  logic [31:0] div_start_r, div_start_nxt;
  logic [15:0] div_dur_r, div_dur_nxt;
  logic        pump_r, pump_nxt;
  logic [31:0] div_elapsed;

  assign cmd   = vttc_pkg::cmd_t'(item.cmd);
  // Limit the count in use to the zones built
  assign n_use = ({1'b0, cfg.zone_count} > ZONES_W) ? ZONES_W : {1'b0, cfg.zone_count};

  // Per-zone next state, all zones in parallel
  for (genvar z = 0; z < ZONES; z++) begin : g_zone
    logic        sel;
    logic [31:0] elapsed;

    assign in_use[z] = 5'(z) < n_use;
    assign sel       = in_use[z] && (item.zone == 4'(z));
    assign elapsed   = item.now_ms - start_r[z];

    always_comb begin
      level_nxt[z]  = level_r[z];
      active_nxt[z] = active_r[z];
      start_nxt[z]  = start_r[z];
      dur_nxt[z]    = dur_r[z];
      unique case (cmd)
        vttc_pkg::CMD_TICK: begin
          if (in_use[z] && active_r[z] && (elapsed >= {16'd0, dur_r[z]})) begin
            active_nxt[z] = 1'b0;
          end
        end
        vttc_pkg::CMD_OPEN, vttc_pkg::CMD_CLOSE: begin
          if (sel) begin
            level_nxt[z]  = (cmd == vttc_pkg::CMD_OPEN);
            active_nxt[z] = 1'b1;
            start_nxt[z]  = item.now_ms;
            dur_nxt[z]    = cfg.zone_travel_ms;
          end
        end
        vttc_pkg::CMD_SAFE: begin
          if (in_use[z]) begin
            level_nxt[z]  = 1'b0;
            active_nxt[z] = 1'b0;
          end
        end
        default: ;
      endcase
    end

    // Hold timer start and latched travel time
    always_ff @(posedge clk) begin
      if (fire) begin
        start_r[z] <= start_nxt[z];
        dur_r[z]   <= dur_nxt[z];
      end
    end

    assign busy[z] = in_use[z] && active_nxt[z];
  end

  assign div_elapsed = item.now_ms - div_start_r;

  // Diverter and pump next state
  always_comb begin
    div_fert_nxt   = div_fert_r;
    div_active_nxt = div_active_r;
    div_start_nxt  = div_start_r;
    div_dur_nxt    = div_dur_r;
    pump_nxt       = pump_r;
    unique case (cmd)
      vttc_pkg::CMD_TICK: begin
        if (div_active_r && (div_elapsed >= {16'd0, div_dur_r})) begin
          div_active_nxt = 1'b0;
        end
      end
      vttc_pkg::CMD_DIVERTER: begin
        div_fert_nxt   = item.fertigate;
        div_active_nxt = 1'b1;
        div_start_nxt  = item.now_ms;
        div_dur_nxt    = cfg.diverter_travel_ms;
      end
      vttc_pkg::CMD_PUMP_ON:  pump_nxt = 1'b1;
      vttc_pkg::CMD_PUMP_OFF: pump_nxt = 1'b0;
      vttc_pkg::CMD_SAFE: begin
        pump_nxt       = 1'b0;
        div_fert_nxt   = 1'b0;
        div_active_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  // Update control state on each fired item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r      <= '0;
      active_r     <= '0;
      div_fert_r   <= 1'b0;
      div_active_r <= 1'b0;
      pump_r       <= 1'b0;
    end else if (fire) begin
      level_r      <= level_nxt;
      active_r     <= active_nxt;
      div_fert_r   <= div_fert_nxt;
      div_active_r <= div_active_nxt;
      pump_r       <= pump_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      div_start_r <= div_start_nxt;
      div_dur_r   <= div_dur_nxt;
    end
  end

  // Pack the result from the post-command state; only zones 0 to 7 are reported
  always_comb begin
    res.zone_levels = '0;
    res.zone_busy   = '0;
    for (int z = 0; z < vttc_pkg::OUT_ZONES; z++) begin
      if (z < ZONES) begin
        res.zone_levels[z] = level_nxt[z];
        res.zone_busy[z]   = busy[z];
      end
    end
    res.diverter_fert = div_fert_nxt;
    res.diverter_busy = div_active_nxt;
    res.pump_on       = pump_nxt;
    res.any_busy      = div_active_nxt || (|busy);
  end

endmodule
